// ===== rtl/sfm_pkg.sv =====
package sfm_pkg;

    // Counter and payload widths.
    localparam int CNT_W  = 32;
    localparam int TIME_W = 48;
    localparam int ADDR_W = 32;
    localparam int PAT_MAX = 64;

    // Configuration register indexes.
    localparam logic REG_RATE_LIMIT = 1'b0;
    localparam logic REG_PCT_LIMIT  = 1'b1;

    // Frame kind codes.
    localparam logic [2:0] KIND_OTHER     = 3'd0;
    localparam logic [2:0] KIND_TCP_SYN   = 3'd1;
    localparam logic [2:0] KIND_TCP_OTHER = 3'd2;
    localparam logic [2:0] KIND_ARP_REPLY = 3'd3;
    localparam logic [2:0] KIND_ARP_OTHER = 3'd4;
    localparam logic [2:0] KIND_IPV4      = 3'd5;

    // Protocol constants.
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_TCP  = 8'h06;
    localparam logic [15:0] HTTP_PORT  = 16'd80;
    localparam logic [16:0] ETH_LEN    = 17'd14;
    localparam logic [16:0] IPV4_MIN   = 17'd30;
    localparam logic [16:0] ARP_MIN    = 17'd22;
    localparam logic [19:0] US_PER_S   = 20'd1000000;
    localparam logic [6:0]  PCT_SCALE  = 7'd100;

    // Reset values of the configuration registers.
    localparam logic [15:0] RATE_RESET = 16'd100;
    localparam logic [6:0]  PCT_RESET  = 7'd90;

    // Host pattern, padded with zero bytes.
    localparam logic [7:0] HOST_PATTERN [PAT_MAX] = '{
        8'h48, 8'h6F, 8'h73, 8'h74, 8'h3A, 8'h20, 8'h77, 8'h77, 8'h77, 8'h2E,
        8'h74, 8'h65, 8'h6C, 8'h65, 8'h67, 8'h72, 8'h61, 8'h70, 8'h68, 8'h2E,
        8'h63, 8'h6F, 8'h2E, 8'h75, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00
    };

    // Decoded summary of one finished frame.
    typedef struct packed {
        logic [2:0]        kind;
        logic              short_f;
        logic              syn;
        logic              arp_hit;
        logic              host_hit;
        logic [ADDR_W-1:0] src;
    } t_frame_sum;

endpackage

// ===== rtl/sfm_parser.sv =====
module sfm_parser #(
    parameter int PATTERN_LENGTH  = 25,
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_clear,
    output sfm_pkg::t_frame_sum o_sum
);
    import sfm_pkg::*;

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_mstart;
    logic          r_seen;
    logic [15:0]   r_etype;
    logic [3:0]    r_ihl;
    logic [15:0]   r_op;
    logic [7:0]    r_proto;
    logic [31:0]   r_src;
    logic [15:0]   r_dport;
    logic [3:0]    r_doff;
    logic [7:0]    r_flags;
    logic [7:0]    r_win [PATTERN_LENGTH];
    logic [7:0]    n_win [PATTERN_LENGTH];

    logic          w_take;
    logic          w_match;
    logic [16:0]   w_pos;
    logic [16:0]   w_t;
    logic [16:0]   w_need;
    logic [16:0]   w_pay;
    logic [PW-1:0] n_mstart;

    assign w_pos  = 17'(r_pos);
    assign w_t    = ETH_LEN + {11'd0, r_ihl, 2'b00};
    assign w_need = (w_t > IPV4_MIN) ? w_t : IPV4_MIN;
    assign w_pay  = w_t + {11'd0, r_doff, 2'b00};
    assign w_take = i_valid && (r_pos < PW'(MAX_FRAME_BYTES));
    assign n_mstart = PW'(w_pos + 17'd1 - 17'(PATTERN_LENGTH));

    // Sliding window with the new byte and the pattern compare.
    always_comb begin
        for (int k = 0; k < PATTERN_LENGTH - 1; k++) begin
            n_win[k] = r_win[k + 1];
        end
        n_win[PATTERN_LENGTH - 1] = i_byte;
        w_match = (w_pos + 17'd1) >= 17'(PATTERN_LENGTH);
        for (int k = 0; k < PATTERN_LENGTH; k++) begin
            if (n_win[k] != HOST_PATTERN[k]) begin
                w_match = 1'b0;
            end
        end
    end

    // Per-frame control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_pos    <= '0;
            r_seen   <= 1'b0;
            r_mstart <= '0;
        end else if (w_take) begin
            r_pos <= r_pos + PW'(1);
            if (w_match) begin
                r_seen   <= 1'b1;
                r_mstart <= n_mstart;
            end
        end
    end

    // Header bytes captured as they stream past.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            for (int k = 0; k < PATTERN_LENGTH; k++) begin
                r_win[k] <= n_win[k];
            end
            if (w_pos == 17'd12) r_etype[15:8] <= i_byte;
            if (w_pos == 17'd13) r_etype[7:0]  <= i_byte;
            if (w_pos == 17'd14) r_ihl         <= i_byte[3:0];
            if (w_pos == 17'd20) r_op[15:8]    <= i_byte;
            if (w_pos == 17'd21) r_op[7:0]     <= i_byte;
            if (w_pos == 17'd23) r_proto       <= i_byte;
            if (w_pos >= 17'd26 && w_pos <= 17'd29) begin
                r_src <= {r_src[23:0], i_byte};
            end
            if (w_pos == w_t + 17'd2)  r_dport[15:8] <= i_byte;
            if (w_pos == w_t + 17'd3)  r_dport[7:0]  <= i_byte;
            if (w_pos == w_t + 17'd12) r_doff        <= i_byte[7:4];
            if (w_pos == w_t + 17'd13) r_flags       <= i_byte;
        end
    end

    // Frame decode from the captured header.
    always_comb begin
        o_sum = '0;
        o_sum.src = r_src;
        o_sum.kind = KIND_OTHER;
        if (w_pos < ETH_LEN) begin
            o_sum.short_f = 1'b1;
        end else if (r_etype == ETYPE_IPV4) begin
            if (w_pos < w_need) begin
                o_sum.short_f = 1'b1;
            end else if (r_proto != PROTO_TCP) begin
                o_sum.kind = KIND_IPV4;
            end else if (w_pos < w_t + 17'd14) begin
                o_sum.short_f = 1'b1;
            end else begin
                o_sum.kind = KIND_TCP_OTHER;
                if (r_flags[5:0] == 6'h02) begin
                    o_sum.kind = KIND_TCP_SYN;
                    o_sum.syn  = 1'b1;
                end
                o_sum.host_hit = (r_dport == HTTP_PORT) && r_seen &&
                                 (17'(r_mstart) >= w_pay);
            end
        end else if (r_etype == ETYPE_ARP) begin
            if (w_pos < ARP_MIN) begin
                o_sum.short_f = 1'b1;
            end else if (r_op == 16'd2 || r_op == 16'd4 || r_op == 16'd6 ||
                         r_op == 16'd9) begin
                o_sum.kind    = KIND_ARP_REPLY;
                o_sum.arp_hit = 1'b1;
            end else begin
                o_sum.kind = KIND_ARP_OTHER;
            end
        end
    end

endmodule

// ===== rtl/sfm_addr_table.sv =====
module sfm_addr_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sfm_pkg::ADDR_W-1:0]  i_src,
    output logic                        o_done,
    output logic                        o_fresh,
    output logic                        o_full
);
    import sfm_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_lim;
    logic [CW-1:0]     r_idx;
    logic [ADDR_W-1:0] r_src;
    logic              r_hit;
    logic              r_rvld;
    logic [ADDR_W-1:0] r_rdata;
    logic [ADDR_W-1:0] r_mem [TABLE_DEPTH];

    logic w_we;
    logic w_re;

    assign o_full  = (r_count == CW'(TABLE_DEPTH));
    assign w_we    = i_start && (r_state == S_IDLE) && !o_full;
    assign w_re    = (r_state == S_SCAN) && (r_idx < r_lim);
    assign o_done  = (r_state == S_DRAIN);
    assign o_fresh = !r_hit;

    // Address store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[AW-1:0]] <= i_src;
        end
        if (w_re) begin
            r_rdata <= r_mem[r_idx[AW-1:0]];
        end
    end

    // Scan over the entries stored before this frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rvld  <= 1'b0;
            r_hit   <= 1'b0;
            r_idx   <= '0;
            r_lim   <= '0;
        end else begin
            r_rvld <= w_re;
            if (r_rvld && (r_rdata == r_src)) begin
                r_hit <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_src   <= i_src;
                        r_hit   <= 1'b0;
                        r_idx   <= '0;
                        r_lim   <= r_count;
                        r_state <= S_SCAN;
                        if (!o_full) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                S_SCAN: begin
                    if (w_re) begin
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/sfm_flag_calc.sv =====
module sfm_flag_calc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sfm_pkg::CNT_W-1:0]   i_unique,
    input  logic [sfm_pkg::CNT_W-1:0]   i_syn,
    input  logic [sfm_pkg::TIME_W-1:0]  i_elapsed,
    input  logic [15:0]                 i_rate,
    input  logic [6:0]                  i_pct,
    output logic                        o_done,
    output logic                        o_flag
);
    import sfm_pkg::*;

    logic        r_v1;
    logic        r_v2;
    logic [51:0] r_pa;
    logic [63:0] r_pb;
    logic [38:0] r_pc;
    logic [38:0] r_pd;
    logic        r_ez;
    logic        r_flag;

    // Valid pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    // Stage one forms the four products, stage two compares them.
    always_ff @(posedge i_clk) begin
        r_pa   <= 52'(i_unique) * 52'(US_PER_S);
        r_pb   <= 64'(i_rate) * 64'(i_elapsed);
        r_pc   <= 39'(i_unique) * 39'(PCT_SCALE);
        r_pd   <= 39'(i_pct) * 39'(i_syn);
        r_ez   <= (i_elapsed == '0);
        r_flag <= (r_ez || (64'(r_pa) > r_pb)) && (r_pc >= r_pd);
    end

    assign o_done = r_v2;
    assign o_flag = r_flag;

endmodule

// ===== rtl/syn_flood_packet_monitor.sv =====
// Channel | Direction | Carries
// s_axis  | in        | tdata: frame_byte, arrival_time_us; tlast: frame_end
// m_axis  | out       | one word per frame: counters and flags; tuser: frame_kind
// cfg     | in        | index 0 rate_limit, index 1 unique_percent_limit
//
// Each frame byte takes one cycle. After the last byte the input stalls through
// the evaluate and output states on a non-SYN frame. A SYN frame scans the address
// store through its single read port, so the input stalls while every address
// stored before that frame is read, and then through the flag calculation and
// output states. The result word sits in an output register, so bytes of the
// next frame are taken while it waits; a result word still waiting at the end of
// the next frame holds the input off. Reset is synchronous; the address store is
// not cleared and only entries written since reset are read.
module syn_flood_packet_monitor #(
    parameter int TABLE_DEPTH     = 1024,
    parameter int PATTERN_LENGTH  = 25,
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [7:0] frame_byte, [55:8] arrival_time_us
    input  logic [55:0]  i_s_axis_tdata,
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [0] attack_flag, [32:1] syn_total, [64:33] unique_syn_total,
    // [96:65] arp_reply_total, [128:97] blocked_host_total,
    // [129] table_full, [130] frame_short, [135:131] zero
    output logic [135:0] o_m_axis_tdata,
    // [2:0] frame_kind
    output logic [2:0]   o_m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    import sfm_pkg::*;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_EVAL,
        ST_SCAN,
        ST_MSTART,
        ST_CALC,
        ST_OUT
    } t_state;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    t_state            r_state;
    logic [15:0]       r_rate;
    logic [6:0]        r_pct;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_first;
    logic              r_first_seen;
    logic [CNT_W-1:0]  r_syn;
    logic [CNT_W-1:0]  r_uniq;
    logic [CNT_W-1:0]  r_arp;
    logic [CNT_W-1:0]  r_host;
    logic              r_attack;
    t_frame_sum        r_sum;
    logic              r_out_valid;
    logic [135:0]      r_out_data;
    logic [2:0]        r_out_kind;

    t_frame_sum w_sum;
    logic       w_in_acc;
    logic       w_tbl_done;
    logic       w_fresh;
    logic       w_full;
    logic       w_calc_done;
    logic       w_calc_flag;
    logic       w_out_free;

    assign o_s_axis_tready = (r_state == ST_RUN);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    sfm_parser #(
        .PATTERN_LENGTH  (PATTERN_LENGTH),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_in_acc),
        .i_byte  (i_s_axis_tdata[7:0]),
        .i_clear (r_state == ST_EVAL),
        .o_sum   (w_sum)
    );

    sfm_addr_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == ST_EVAL) && w_sum.syn),
        .i_src   (w_sum.src),
        .o_done  (w_tbl_done),
        .o_fresh (w_fresh),
        .o_full  (w_full)
    );

    sfm_flag_calc u_calc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == ST_MSTART),
        .i_unique  (r_uniq),
        .i_syn     (r_syn),
        .i_elapsed (r_now - r_first),
        .i_rate    (r_rate),
        .i_pct     (r_pct),
        .o_done    (w_calc_done),
        .o_flag    (w_calc_flag)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
            r_pct  <= PCT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RATE_LIMIT: r_rate <= i_cfg_data;
                REG_PCT_LIMIT:  r_pct  <= i_cfg_data[6:0];
                default:        r_rate <= r_rate;
            endcase
        end
    end

    // End-of-frame sequencer, counters and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_RUN;
            r_first_seen <= 1'b0;
            r_first      <= '0;
            r_syn        <= '0;
            r_uniq       <= '0;
            r_arp        <= '0;
            r_host       <= '0;
            r_attack     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // The output state reloads the word itself when it is taken.
            if (r_out_valid && i_m_axis_tready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_RUN: begin
                    if (w_in_acc && i_s_axis_tlast) begin
                        r_now   <= i_s_axis_tdata[55:8];
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    r_sum <= w_sum;
                    if (w_sum.arp_hit && r_arp != CNT_MAX) begin
                        r_arp <= r_arp + CNT_W'(1);
                    end
                    if (w_sum.host_hit && r_host != CNT_MAX) begin
                        r_host <= r_host + CNT_W'(1);
                    end
                    if (w_sum.syn) begin
                        if (r_syn != CNT_MAX) begin
                            r_syn <= r_syn + CNT_W'(1);
                        end
                        if (!r_first_seen) begin
                            r_first      <= r_now;
                            r_first_seen <= 1'b1;
                        end
                        r_state <= ST_SCAN;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_SCAN: begin
                    if (w_tbl_done) begin
                        if (w_fresh && r_uniq != CNT_MAX) begin
                            r_uniq <= r_uniq + CNT_W'(1);
                        end
                        r_state <= ST_MSTART;
                    end
                end
                ST_MSTART: begin
                    r_state <= ST_CALC;
                end
                ST_CALC: begin
                    if (w_calc_done) begin
                        r_attack <= w_calc_flag;
                        r_state  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {5'd0, r_sum.short_f, w_full, r_host, r_arp,
                                        r_uniq, r_syn, r_attack};
                        r_out_kind  <= r_sum.kind;
                        r_state     <= ST_RUN;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_kind;

`ifndef SYNTH
    // The table never empties once it has filled.
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_full) |-> w_full)
        else $error("address table full flag dropped");

    // Unique sources never outnumber SYN frames.
    a_uniq_le_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_uniq <= r_syn)
        else $error("unique count above SYN count");

    // A SYN result always carries a nonzero SYN count.
    a_syn_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_TCP_SYN) |-> (r_out_data[32:1] != '0))
        else $error("SYN result with zero SYN count");

    // The input is held off while a frame is being finished.
    a_stall_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_axis_tlast) |=> !o_s_axis_tready)
        else $error("input taken during end-of-frame work");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import sfm_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int PAT_LEN     = 25;
    localparam int MAX_BYTES   = 2048;
    localparam int HDR_KEEP    = 88;
    localparam int SETTLE      = 1300;
    localparam int CYCLE_LIMIT = 3000000;

    typedef logic [7:0] t_frame[$];

    // One byte word on the input stream.
    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic [47:0] stamp;
    } t_wire_byte;

    // Counters and flags reported after one frame.
    typedef struct {
        logic        attack;
        logic [31:0] syn_n;
        logic [31:0] uniq_n;
        logic [31:0] arp_n;
        logic [31:0] host_n;
        logic [2:0]  kind;
        logic        full;
        logic        short_f;
    } t_frame_report;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [55:0]  i_s_axis_tdata = '0;
    logic         i_s_axis_tlast = 1'b0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [135:0] o_m_axis_tdata;
    logic [2:0]   o_m_axis_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_index = REG_RATE_LIMIT;
    logic [15:0]  i_cfg_data = '0;

    syn_flood_packet_monitor uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    t_wire_byte    byte_feed[$];
    t_frame_report pending_reports[$];
    int unsigned   errors = 0;
    int unsigned   cycles = 0;
    int unsigned   frames_seen = 0;
    int unsigned   syn_frames = 0;
    bit            calm = 0;

    // Shadow of the monitor state.
    logic [7:0]  hdr_bytes[HDR_KEEP];
    logic [7:0]  win[PAT_LEN];
    bit          pat_seen;
    int unsigned pat_start;
    int unsigned byte_pos;
    logic [31:0] src_table[TABLE_DEPTH];
    int unsigned src_count;
    logic [31:0] syn_cnt, uniq_cnt, arp_cnt, host_cnt;
    logic [47:0] first_syn_us;
    bit          first_syn_done;
    bit          attack_now;
    logic [15:0] rate_lim;
    logic [6:0]  pct_lim;

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] hdr_at(int unsigned i);
        return i < HDR_KEEP ? hdr_bytes[i] : 8'h00;
    endfunction

    function automatic void bump(ref logic [31:0] c);
        if (c != 32'hFFFF_FFFF) c++;
    endfunction

    // Count a SYN frame, store its source and recompute the attack flag.
    function automatic void note_syn(logic [31:0] src, logic [47:0] now);
        bit          fresh;
        logic [47:0] elapsed;
        bit          rate_hit, pct_hit;
        fresh = 1;
        if (!first_syn_done) begin
            first_syn_us   = now;
            first_syn_done = 1;
        end
        bump(syn_cnt);
        for (int unsigned i = 0; i < src_count; i++)
            if (src_table[i] == src) fresh = 0;
        if (src_count < TABLE_DEPTH) begin
            src_table[src_count] = src;
            src_count++;
        end
        if (fresh) bump(uniq_cnt);
        elapsed  = now - first_syn_us;
        rate_hit = (elapsed == 0) ||
                   (128'(uniq_cnt) * 128'd1000000 > 128'(rate_lim) * 128'(elapsed));
        pct_hit  = 64'(uniq_cnt) * 64'd100 >= 64'(pct_lim) * 64'(syn_cnt);
        attack_now = rate_hit && pct_hit;
    endfunction

    // Classify a finished frame and update the counters.
    function automatic logic [2:0] classify(logic [47:0] now, output logic short_f);
        int unsigned len, hl, need, t, doff;
        logic [15:0] etype, dport, op;
        logic [7:0]  flags;
        logic [2:0]  kind;
        len     = byte_pos;
        short_f = 0;
        if (len < 14) begin
            short_f = 1;
            return KIND_OTHER;
        end
        etype = {hdr_at(12), hdr_at(13)};
        if (etype == ETYPE_IPV4) begin
            hl   = (hdr_at(14) & 8'h0F) * 4;
            need = (14 + hl > 30) ? 14 + hl : 30;
            if (len < need) begin
                short_f = 1;
                return KIND_OTHER;
            end
            if (hdr_at(23) != PROTO_TCP) return KIND_IPV4;
            t = 14 + hl;
            if (len < t + 14) begin
                short_f = 1;
                return KIND_OTHER;
            end
            flags = hdr_at(t + 13);
            dport = {hdr_at(t + 2), hdr_at(t + 3)};
            doff  = (hdr_at(t + 12) >> 4) * 4;
            kind  = KIND_TCP_OTHER;
            if ((flags & 8'h3F) == 8'h02) begin
                note_syn({hdr_at(26), hdr_at(27), hdr_at(28), hdr_at(29)}, now);
                kind = KIND_TCP_SYN;
            end
            if (dport == HTTP_PORT && pat_seen && pat_start >= t + doff) bump(host_cnt);
            return kind;
        end
        if (etype == ETYPE_ARP) begin
            if (len < 22) begin
                short_f = 1;
                return KIND_OTHER;
            end
            op = {hdr_at(20), hdr_at(21)};
            if (op == 2 || op == 4 || op == 6 || op == 9) begin
                bump(arp_cnt);
                return KIND_ARP_REPLY;
            end
            return KIND_ARP_OTHER;
        end
        return KIND_OTHER;
    endfunction

    // Advance the shadow state by one accepted byte word.
    function automatic void track_frame_byte(t_wire_byte w);
        bit            hit;
        t_frame_report r;
        logic          sh;
        if (byte_pos < MAX_BYTES) begin
            if (byte_pos < HDR_KEEP) hdr_bytes[byte_pos] = w.data;
            for (int i = 0; i < PAT_LEN - 1; i++) win[i] = win[i + 1];
            win[PAT_LEN - 1] = w.data;
            hit = 1;
            for (int i = 0; i < PAT_LEN; i++)
                if (win[i] != HOST_PATTERN[i]) hit = 0;
            if (byte_pos + 1 >= PAT_LEN && hit) begin
                pat_seen  = 1;
                pat_start = byte_pos + 1 - PAT_LEN;
            end
            byte_pos++;
        end
        if (!w.last) return;
        r.kind    = classify(w.stamp, sh);
        r.short_f = sh;
        r.attack  = attack_now;
        r.syn_n   = syn_cnt;
        r.uniq_n  = uniq_cnt;
        r.arp_n   = arp_cnt;
        r.host_n  = host_cnt;
        r.full    = src_count >= TABLE_DEPTH;
        pending_reports.push_back(r);
        byte_pos  = 0;
        pat_seen  = 0;
        pat_start = 0;
        foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
    endfunction

    // Idle length: mostly short, now and then long, none in calm stretches.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    // Input driver.
    t_wire_byte  cur;
    int unsigned in_gap = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                track_frame_byte(cur);
                if (cur.last) calm = ($urandom_range(0, 9) == 0);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (byte_feed.size() > 0) begin
                    cur = byte_feed.pop_front();
                    i_s_axis_tdata  <= {cur.stamp, cur.data};
                    i_s_axis_tlast  <= cur.last;
                    i_s_axis_tvalid <= 1'b1;
                    in_gap = pick_gap();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $realtime, cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            errors++;
            $display("%0t mismatch in %s: expected %h, got %h", $realtime, name, exp_v, got_v);
        end
    endtask

    // Result monitor and output stalls.
    int unsigned out_stall = 0;
    always @(posedge i_clk) begin
        t_frame_report e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            frames_seen++;
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t unexpected result word %h", $realtime, o_m_axis_tdata);
            end else begin
                e = pending_reports.pop_front();
                if (e.kind == KIND_TCP_SYN) syn_frames++;
                check_field("attack_flag", e.attack, o_m_axis_tdata[0]);
                check_field("syn_total", e.syn_n, o_m_axis_tdata[32:1]);
                check_field("unique_syn_total", e.uniq_n, o_m_axis_tdata[64:33]);
                check_field("arp_reply_total", e.arp_n, o_m_axis_tdata[96:65]);
                check_field("blocked_host_total", e.host_n, o_m_axis_tdata[128:97]);
                check_field("table_full", e.full, o_m_axis_tdata[129]);
                check_field("frame_short", e.short_f, o_m_axis_tdata[130]);
                check_field("frame_kind", e.kind, o_m_axis_tuser);
            end
        end
        if (out_stall > 0) begin
            out_stall--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            out_stall = pick_gap();
        end
    end

    // Frame builders.
    function automatic t_frame rand_bytes(int unsigned n);
        t_frame f;
        repeat (n) f.push_back($urandom_range(0, 255));
        return f;
    endfunction

    function automatic void put_pattern(ref t_frame f, input int unsigned at);
        while (f.size() < at + PAT_LEN) f.push_back($urandom_range(0, 255));
        for (int i = 0; i < PAT_LEN; i++) f[at + i] = HOST_PATTERN[i];
    endfunction

    function automatic t_frame tcp_frame(int unsigned ihl, int unsigned doff, logic [7:0] flags,
                                         logic [31:0] src, logic [15:0] dport,
                                         int unsigned plen);
        t_frame      f;
        int unsigned t, n;
        t = 14 + 4 * ihl;
        n = t + ((4 * doff > 14) ? 4 * doff : 14) + plen;
        if (n < 30) n = 30;
        f = rand_bytes(n);
        f[12] = ETYPE_IPV4[15:8];
        f[13] = ETYPE_IPV4[7:0];
        f[14] = {4'h4, 4'(ihl)};
        f[23] = PROTO_TCP;
        {f[26], f[27], f[28], f[29]} = src;
        {f[t + 2], f[t + 3]} = dport;
        f[t + 12] = {4'(doff), 4'($urandom_range(0, 15))};
        f[t + 13] = flags;
        return f;
    endfunction

    function automatic t_frame arp_frame(logic [15:0] op, int unsigned extra);
        t_frame f;
        f = rand_bytes(22 + extra);
        f[12] = ETYPE_ARP[15:8];
        f[13] = ETYPE_ARP[7:0];
        {f[20], f[21]} = op;
        return f;
    endfunction

    function automatic logic [7:0] syn_flags();
        return 8'h02 | (8'($urandom_range(0, 3)) << 6);
    endfunction

    logic [47:0] now_us = 48'd1000;

    task automatic send_frame(t_frame f);
        t_wire_byte w;
        now_us += $urandom_range(0, 3000);
        foreach (f[i]) begin
            w.data  = f[i];
            w.last  = (i == f.size() - 1);
            w.stamp = w.last ? now_us : {$urandom, 16'($urandom)};
            byte_feed.push_back(w);
        end
    endtask

    logic [31:0] src_pool[8];

    // One random frame, mostly well formed.
    task automatic send_random_frame();
        t_frame      f;
        int unsigned r, ihl, doff, cut;
        logic [31:0] src;
        r    = $urandom_range(0, 99);
        ihl  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : 5;
        doff = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : 5;
        src  = ($urandom_range(0, 2) == 0) ? $urandom : src_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 19) == 0) now_us = {$urandom, 16'($urandom)};
        if (r < 40) begin
            f = tcp_frame(ihl, doff, syn_flags(), src,
                          $urandom_range(0, 1) ? HTTP_PORT : 16'($urandom), $urandom_range(0, 40));
        end else if (r < 60) begin
            f = tcp_frame(ihl, doff, $urandom_range(0, 255), src,
                          $urandom_range(0, 1) ? HTTP_PORT : 16'($urandom), $urandom_range(0, 30));
            if ($urandom_range(0, 1))
                put_pattern(f, 14 + 4 * ihl + 4 * doff + $urandom_range(0, 10));
            else if ($urandom_range(0, 3) == 0)
                put_pattern(f, 14 + 4 * ihl + $urandom_range(0, 4));
        end else if (r < 70) begin
            f = tcp_frame(ihl, doff, syn_flags(), src, HTTP_PORT, 4);
            f[23] = $urandom_range(0, 1) ? 8'h11 : 8'($urandom);
        end else if (r < 82) begin
            f = arp_frame($urandom_range(0, 1) ? 16'($urandom_range(0, 10)) : 16'($urandom),
                          $urandom_range(0, 20));
        end else if (r < 90) begin
            f = rand_bytes($urandom_range(1, 80));
        end else begin
            f = (r < 95) ? tcp_frame(ihl, doff, syn_flags(), src, HTTP_PORT, 0)
                         : arp_frame(16'd2, 0);
            cut = $urandom_range(1, f.size() - 1);
            while (f.size() > cut) void'(f.pop_back());
        end
        send_frame(f);
    endtask

    // Wait until every word has gone through and the block is idle.
    task automatic drain();
        while (byte_feed.size() > 0 || i_s_axis_tvalid || pending_reports.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_RATE_LIMIT) rate_lim = val;
        else pct_lim = 7'(val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int unsigned n_bytes);
        int unsigned target;
        target = byte_feed.size() + n_bytes;
        while (byte_feed.size() < target) send_random_frame();
        drain();
    endtask

    // Stimulus and end of run.
    initial begin
        t_frame f;
        byte_pos = 0;
        pat_seen = 0;
        pat_start = 0;
        src_count = 0;
        syn_cnt = 0;
        uniq_cnt = 0;
        arp_cnt = 0;
        host_cnt = 0;
        first_syn_us = 0;
        first_syn_done = 0;
        attack_now = 0;
        rate_lim = RATE_RESET;
        pct_lim = PCT_RESET;
        foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
        foreach (win[i]) win[i] = 8'h00;
        foreach (src_pool[i]) src_pool[i] = $urandom;
        src_pool[0] = 32'h0000_0000;
        src_pool[1] = 32'hFFFF_FFFF;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames: short headers, every kind, odd lengths, the pattern.
        send_frame(rand_bytes(1));
        send_frame(rand_bytes(13));
        f = tcp_frame(5, 5, 8'h02, src_pool[0], HTTP_PORT, 0);
        f = f[0:28];
        send_frame(f);
        f = tcp_frame(5, 5, 8'h02, src_pool[1], HTTP_PORT, 0);
        f = f[0:46];
        send_frame(f);
        f = arp_frame(16'd2, 0);
        f = f[0:20];
        send_frame(f);
        for (int op = 0; op <= 10; op += 1) send_frame(arp_frame(16'(op), 0));
        send_frame(arp_frame(16'hFFFF, 3));
        f = tcp_frame(5, 5, 8'h02, src_pool[2], HTTP_PORT, 10);
        f[23] = 8'h11;
        send_frame(f);
        send_frame(tcp_frame(5, 5, 8'hFF, src_pool[2], 16'hFFFF, 0));
        f = tcp_frame(5, 5, 8'h02, src_pool[2], HTTP_PORT, 0);
        put_pattern(f, 54);
        send_frame(f);
        f = tcp_frame(5, 15, 8'h12, src_pool[3], HTTP_PORT, 0);
        put_pattern(f, 40);
        send_frame(f);
        send_frame(tcp_frame(0, 0, 8'hC2, src_pool[2], HTTP_PORT, 0));
        send_frame(tcp_frame(15, 0, 8'h02, src_pool[3], HTTP_PORT, 0));
        now_us = 48'hFFFF_FFFF_FFF0;
        send_frame(tcp_frame(5, 5, 8'h02, src_pool[4], 16'd0, 0));
        drain();

        // Random traffic under several limit settings: reset values, then extremes, then other values.
        random_phase(250);
        write_reg(REG_RATE_LIMIT, 16'd0);
        write_reg(REG_PCT_LIMIT, 16'd0);
        random_phase(250);
        write_reg(REG_RATE_LIMIT, 16'hFFFF);
        write_reg(REG_PCT_LIMIT, 16'd100);
        random_phase(250);
        write_reg(REG_RATE_LIMIT, 16'($urandom_range(1, 3000)));
        write_reg(REG_PCT_LIMIT, 16'($urandom_range(1, 99)));
        random_phase(250);
        write_reg(REG_RATE_LIMIT, 16'd50);
        random_phase(100);

        $display("Run covered %0d frame results, %0d of them SYN frames, over five limit settings",
                 frames_seen, syn_frames);
        $display("including short, ARP, odd header length, host pattern and time wrap cases.");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
